// ----- rtl/forward_warp_splat_accumulate_assert.svh -----
// Assertion macros for the port checker of the splat accumulator.
// No dependencies; included by fwsa_port_checker.sv.
`ifndef FORWARD_WARP_SPLAT_ACCUMULATE_ASSERT_SVH
`define FORWARD_WARP_SPLAT_ACCUMULATE_ASSERT_SVH
// Same-cycle implication, held off while rst is high.
`define FWSA_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// Next-cycle implication, held off while rst is high.
`define FWSA_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`endif

// ----- rtl/fwsa_pkg.sv -----
// Package for the forward-warp splat accumulator: widths, register map,
// shared types, state encoding and the warp target arithmetic. No dependencies.
package fwsa_pkg;

   // default destination store geometry
   localparam int DEST_COLS_DEFAULT = 64;
   localparam int DEST_ROWS_DEFAULT = 64;

   // stream widths (packed payloads, padded to whole bytes)
   localparam int REQ_TDATA_W = 72;
   localparam int RSP_TDATA_W = 64;

   // entry widths and saturation limits
   localparam int VALUE_W  = 20;
   localparam int WEIGHT_W = 16;
   localparam logic [VALUE_W-1:0]  VALUE_MAX  = '1;
   localparam logic [WEIGHT_W-1:0] WEIGHT_MAX = '1;

   // configuration register map (index = paddr[4:2])
   localparam int CSR_ADDR_W = 5;
   localparam logic [2:0] REG_TIME_FRACTION = 3'd0;
   localparam logic [2:0] REG_DEST_LEFT     = 3'd1;
   localparam logic [2:0] REG_DEST_TOP      = 3'd2;
   localparam logic [2:0] REG_DEST_WIDTH    = 3'd3;
   localparam logic [2:0] REG_DEST_HEIGHT   = 3'd4;
   localparam logic [2:0] REG_SPLAT_KIND    = 3'd5;

   // register reset values
   localparam logic [8:0] TIME_FRACTION_RST = 9'd256;
   localparam logic [9:0] DEST_LEFT_RST     = 10'd0;
   localparam logic [9:0] DEST_TOP_RST      = 10'd0;
   localparam logic [6:0] DEST_WIDTH_RST    = 7'd64;
   localparam logic [6:0] DEST_HEIGHT_RST   = 7'd64;
   localparam logic [1:0] SPLAT_KIND_RST    = 2'd0;

   // splat_kind bit decode
   localparam int KIND_OVERWRITE_BIT = 0;
   localparam int KIND_TRUNCATE_BIT  = 1;

   // item modes
   localparam logic MODE_SPLAT = 1'b0;
   localparam logic MODE_READ  = 1'b1;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_MUL,
      ST_TGT,
      ST_ADDR,
      ST_RD,
      ST_RMW
   } state_type;

   typedef struct packed {
      logic [VALUE_W-1:0]  value;
      logic [WEIGHT_W-1:0] weight;
   } entry_type;

   typedef struct packed {
      logic rd_en;
      logic wr_en;
   } store_ctl_type;

   // Target coordinate from position and scaled flow (12 fractional bits).
   // Truncate: (pos*4096 - prod) / 4096 toward zero.
   // Round: pos - round(prod / 4096), ties to even.
   function automatic logic signed [11:0] warp_target(input logic [9:0] pos,
                                                      input logic signed [22:0] prod,
                                                      input logic trunc);
      logic signed [23:0] t;
      logic signed [23:0] t_adj;
      logic signed [10:0] q;
      logic [11:0]        frac;
      logic               inc;
      logic signed [12:0] diff;
      t     = $signed({2'b00, pos, 12'd0}) - $signed({prod[22], prod});
      t_adj = t[23] ? t + 24'sd4095 : t;
      q     = prod[22:12];
      frac  = prod[11:0];
      inc   = (frac > 12'd2048) || ((frac == 12'd2048) && q[0]);
      diff  = $signed({3'b000, pos}) - $signed({{2{q[10]}}, q}) - $signed({12'd0, inc});
      return trunc ? t_adj[23:12] : diff[11:0];
   endfunction

endpackage

// ----- rtl/fwsa_store.sv -----
// Value and weight stores of the splat accumulator: one shared address,
// one write or one registered read per cycle. Depends on fwsa_pkg.
module fwsa_store #(
   parameter int  DEPTH  = fwsa_pkg::DEST_COLS_DEFAULT * fwsa_pkg::DEST_ROWS_DEFAULT,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                    clock,
   input  fwsa_pkg::store_ctl_type ctl,
   input  logic [ADDR_W-1:0]       addr,
   input  fwsa_pkg::entry_type     wdata,
   output fwsa_pkg::entry_type     rdata
);

   logic [fwsa_pkg::VALUE_W-1:0]  value_mem  [DEPTH];
   logic [fwsa_pkg::WEIGHT_W-1:0] weight_mem [DEPTH];
   fwsa_pkg::entry_type           rdata_ff;

   // write port
   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         value_mem[addr]  <= wdata.value;
         weight_mem[addr] <= wdata.weight;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (ctl.rd_en) begin
         rdata_ff.value  <= value_mem[addr];
         rdata_ff.weight <= weight_mem[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ----- rtl/forward_warp_splat_accumulate.sv -----
// Forward-warp splat accumulator, top level: CSR block, item sequencer,
// warp arithmetic and output register. Depends on fwsa_pkg and fwsa_store.
//
// Usage:
//   req_* carries one item per transaction: a splat (tuser = 0) or a
//   read-and-clear of one destination entry (tuser = 1). rsp_* returns one
//   result per item, in order. csr_* is an APB-style port for the six
//   configuration registers; the user must write them only while the
//   block is idle, which the block itself does not enforce.
// Sequence:
//   One item is in flight at a time, passing through accept, flow multiply,
//   target, store index, store read, and update and write back; its result
//   is loaded into the output register as the sequencer returns to idle.
//   The single store port reads and writes each entry in separate cycles.
// Reset:
//   After reset a clearing pass zeroes all DEST_ROWS*DEST_COLS entries, one a
//   cycle; req_tready stays low until it is done. Registers take their
//   documented reset values at once.
// Stalls:
//   A result waits in the output register while rsp_tready is low; the next
//   item may be accepted and worked on, but holds before its write back until
//   the output register is free.
module forward_warp_splat_accumulate #(
   parameter int DEST_COLS = fwsa_pkg::DEST_COLS_DEFAULT,
   parameter int DEST_ROWS = fwsa_pkg::DEST_ROWS_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   // request stream
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // [9:0] src_row, [19:10] src_col, [27:20] pixel, [41:28] flow_x,
   // [55:42] flow_y, [61:56] read_row, [67:62] read_col, [71:68] zero
   input  logic [fwsa_pkg::REQ_TDATA_W-1:0]   req_tdata,
   // [0] mode
   input  logic                               req_tuser,
   // response stream
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // [11:0] target_row, [23:12] target_col, [43:24] value_sum,
   // [59:44] weight_count, [63:60] zero
   output logic [fwsa_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   // [0] landed
   output logic                               rsp_tuser,
   // configuration port
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [fwsa_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [31:0]                        csr_pwdata,
   output logic [31:0]                        csr_prdata,
   output logic                               csr_pready
);

   localparam int DEPTH  = DEST_ROWS * DEST_COLS;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);
   localparam logic [10:0] ROW_LIM = 11'(DEST_ROWS);
   localparam logic [10:0] COL_LIM = 11'(DEST_COLS);

   // sequencer
   fwsa_pkg::state_type state_ff, state_in;
   logic [ADDR_W-1:0]   clr_addr_ff, clr_addr_in;
   logic                rsp_load;

   // configuration registers
   logic [8:0] time_fraction_ff;
   logic [9:0] dest_left_ff;
   logic [9:0] dest_top_ff;
   logic [6:0] dest_width_ff;
   logic [6:0] dest_height_ff;
   logic [1:0] splat_kind_ff;
   logic       csr_wr;
   logic [2:0] csr_idx;

   // item payload
   logic              mode_ff;
   logic [9:0]        src_row_ff, src_col_ff;
   logic [7:0]        pixel_ff;
   logic signed [13:0] flow_x_ff, flow_y_ff;
   logic [5:0]        read_row_ff, read_col_ff;

   // arithmetic stages
   logic signed [22:0] prod_x_in, prod_y_in, prod_x_ff, prod_y_ff;
   logic signed [11:0] tgt_row_in, tgt_col_in, tgt_row_ff, tgt_col_ff;
   logic signed [12:0] rel_row, rel_col;
   logic [10:0]        size_row, size_col;
   logic               row_ok, col_ok;
   logic [6:0]         idx_row, idx_col;
   logic               hit_in, hit_ff;
   logic [ADDR_W-1:0]  idx_in, idx_ff;

   // store port
   fwsa_pkg::store_ctl_type store_ctl;
   logic [ADDR_W-1:0]       store_addr;
   fwsa_pkg::entry_type     store_wdata, rd_entry, upd_entry;

   // result
   logic [fwsa_pkg::VALUE_W-1:0]    rsp_value;
   logic [fwsa_pkg::WEIGHT_W-1:0]   rsp_weight;
   logic [fwsa_pkg::VALUE_W:0]      value_sum_wide;
   logic signed [11:0]              out_row, out_col;
   logic                            out_landed;
   logic                            rsp_tvalid_ff;
   logic [fwsa_pkg::RSP_TDATA_W-1:0] rsp_tdata_ff;
   logic                            rsp_tuser_ff;

   // ---------------- configuration port ----------------
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_idx    = csr_paddr[4:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         time_fraction_ff <= fwsa_pkg::TIME_FRACTION_RST;
         dest_left_ff     <= fwsa_pkg::DEST_LEFT_RST;
         dest_top_ff      <= fwsa_pkg::DEST_TOP_RST;
         dest_width_ff    <= fwsa_pkg::DEST_WIDTH_RST;
         dest_height_ff   <= fwsa_pkg::DEST_HEIGHT_RST;
         splat_kind_ff    <= fwsa_pkg::SPLAT_KIND_RST;
      end else if (csr_wr) begin
         unique case (csr_idx)
            fwsa_pkg::REG_TIME_FRACTION: time_fraction_ff <= csr_pwdata[8:0];
            fwsa_pkg::REG_DEST_LEFT:     dest_left_ff     <= csr_pwdata[9:0];
            fwsa_pkg::REG_DEST_TOP:      dest_top_ff      <= csr_pwdata[9:0];
            fwsa_pkg::REG_DEST_WIDTH:    dest_width_ff    <= csr_pwdata[6:0];
            fwsa_pkg::REG_DEST_HEIGHT:   dest_height_ff   <= csr_pwdata[6:0];
            fwsa_pkg::REG_SPLAT_KIND:    splat_kind_ff    <= csr_pwdata[1:0];
            default: ;
         endcase
      end
   end

   // register readback
   always_comb begin
      unique case (csr_idx)
         fwsa_pkg::REG_TIME_FRACTION: csr_prdata = 32'(time_fraction_ff);
         fwsa_pkg::REG_DEST_LEFT:     csr_prdata = 32'(dest_left_ff);
         fwsa_pkg::REG_DEST_TOP:      csr_prdata = 32'(dest_top_ff);
         fwsa_pkg::REG_DEST_WIDTH:    csr_prdata = 32'(dest_width_ff);
         fwsa_pkg::REG_DEST_HEIGHT:   csr_prdata = 32'(dest_height_ff);
         fwsa_pkg::REG_SPLAT_KIND:    csr_prdata = 32'(splat_kind_ff);
         default:                     csr_prdata = 32'd0;
      endcase
   end

   // ---------------- sequencer ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= fwsa_pkg::ST_CLEAR;
         clr_addr_ff <= '0;
      end else begin
         state_ff    <= state_in;
         clr_addr_ff <= clr_addr_in;
      end
   end

   always_comb begin
      state_in    = state_ff;
      clr_addr_in = clr_addr_ff;
      req_tready  = 1'b0;
      store_ctl   = '0;
      store_addr  = idx_ff;
      store_wdata = '0;
      rsp_load    = 1'b0;
      unique case (state_ff)
         fwsa_pkg::ST_CLEAR: begin
            // zero one entry a cycle
            store_ctl.wr_en = 1'b1;
            store_addr      = clr_addr_ff;
            clr_addr_in     = clr_addr_ff + 1'b1;
            if (clr_addr_ff == LAST_ADDR) begin
               clr_addr_in = '0;
               state_in    = fwsa_pkg::ST_IDLE;
            end
         end
         fwsa_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               state_in = fwsa_pkg::ST_MUL;
            end
         end
         fwsa_pkg::ST_MUL:  state_in = fwsa_pkg::ST_TGT;
         fwsa_pkg::ST_TGT:  state_in = fwsa_pkg::ST_ADDR;
         fwsa_pkg::ST_ADDR: state_in = fwsa_pkg::ST_RD;
         fwsa_pkg::ST_RD: begin
            store_ctl.rd_en = hit_ff;
            state_in        = fwsa_pkg::ST_RMW;
         end
         fwsa_pkg::ST_RMW: begin
            // write back and hand over once the output register is free
            if (!rsp_tvalid_ff || rsp_tready) begin
               rsp_load        = 1'b1;
               store_ctl.wr_en = hit_ff;
               store_wdata     = upd_entry;
               state_in        = fwsa_pkg::ST_IDLE;
            end
         end
         default: state_in = fwsa_pkg::ST_CLEAR;
      endcase
   end

   // ---------------- item capture ----------------
   always_ff @(posedge clock) begin
      if (state_ff == fwsa_pkg::ST_IDLE && req_tvalid) begin
         mode_ff     <= req_tuser;
         src_row_ff  <= req_tdata[9:0];
         src_col_ff  <= req_tdata[19:10];
         pixel_ff    <= req_tdata[27:20];
         flow_x_ff   <= req_tdata[41:28];
         flow_y_ff   <= req_tdata[55:42];
         read_row_ff <= req_tdata[61:56];
         read_col_ff <= req_tdata[67:62];
      end
   end

   // ---------------- flow scaling ----------------
   assign prod_x_in = $signed({{9{flow_x_ff[13]}}, flow_x_ff})
                    * $signed({14'd0, time_fraction_ff});
   assign prod_y_in = $signed({{9{flow_y_ff[13]}}, flow_y_ff})
                    * $signed({14'd0, time_fraction_ff});

   always_ff @(posedge clock) begin
      if (state_ff == fwsa_pkg::ST_MUL) begin
         prod_x_ff <= prod_x_in;
         prod_y_ff <= prod_y_in;
      end
   end

   // ---------------- target coordinates ----------------
   assign tgt_row_in = fwsa_pkg::warp_target(src_row_ff, prod_y_ff,
                                             splat_kind_ff[fwsa_pkg::KIND_TRUNCATE_BIT]);
   assign tgt_col_in = fwsa_pkg::warp_target(src_col_ff, prod_x_ff,
                                             splat_kind_ff[fwsa_pkg::KIND_TRUNCATE_BIT]);

   always_ff @(posedge clock) begin
      if (state_ff == fwsa_pkg::ST_TGT) begin
         tgt_row_ff <= tgt_row_in;
         tgt_col_ff <= tgt_col_in;
      end
   end

   // ---------------- rectangle test and store index ----------------
   assign rel_row  = $signed({tgt_row_ff[11], tgt_row_ff}) - $signed({3'b000, dest_top_ff});
   assign rel_col  = $signed({tgt_col_ff[11], tgt_col_ff}) - $signed({3'b000, dest_left_ff});
   // rectangle clamped to the store
   assign size_row = ({4'd0, dest_height_ff} < ROW_LIM) ? {4'd0, dest_height_ff} : ROW_LIM;
   assign size_col = ({4'd0, dest_width_ff} < COL_LIM) ? {4'd0, dest_width_ff} : COL_LIM;
   assign row_ok   = !rel_row[12] && (rel_row[11:0] < {1'b0, size_row});
   assign col_ok   = !rel_col[12] && (rel_col[11:0] < {1'b0, size_col});

   always_comb begin
      if (mode_ff == fwsa_pkg::MODE_READ) begin
         idx_row = {1'b0, read_row_ff};
         idx_col = {1'b0, read_col_ff};
         hit_in  = ({5'd0, read_row_ff} < ROW_LIM) && ({5'd0, read_col_ff} < COL_LIM);
      end else begin
         idx_row = rel_row[6:0];
         idx_col = rel_col[6:0];
         hit_in  = row_ok && col_ok;
      end
   end

   assign idx_in = ADDR_W'(idx_row) * ADDR_W'(DEST_COLS) + ADDR_W'(idx_col);

   always_ff @(posedge clock) begin
      if (state_ff == fwsa_pkg::ST_ADDR) begin
         hit_ff <= hit_in;
         idx_ff <= idx_in;
      end
   end

   // ---------------- store ----------------
   fwsa_store #(
      .DEPTH (DEPTH)
   ) u_store (
      .clock (clock),
      .ctl   (store_ctl),
      .addr  (store_addr),
      .wdata (store_wdata),
      .rdata (rd_entry)
   );

   // ---------------- update and result ----------------
   assign value_sum_wide = {1'b0, rd_entry.value} + {13'd0, pixel_ff};

   always_comb begin
      upd_entry  = '0;
      rsp_value  = '0;
      rsp_weight = '0;
      out_row    = tgt_row_ff;
      out_col    = tgt_col_ff;
      out_landed = hit_ff;
      if (mode_ff == fwsa_pkg::MODE_READ) begin
         // read and clear: entry goes out, zero goes back
         out_row    = '0;
         out_col    = '0;
         out_landed = 1'b1;
         if (hit_ff) begin
            rsp_value  = rd_entry.value;
            rsp_weight = rd_entry.weight;
         end
      end else if (splat_kind_ff[fwsa_pkg::KIND_OVERWRITE_BIT]) begin
         upd_entry.value  = {12'd0, pixel_ff};
         upd_entry.weight = 16'd1;
      end else begin
         // saturating accumulate
         upd_entry.value  = value_sum_wide[fwsa_pkg::VALUE_W] ? fwsa_pkg::VALUE_MAX
                                                              : value_sum_wide[19:0];
         upd_entry.weight = (rd_entry.weight == fwsa_pkg::WEIGHT_MAX)
                            ? rd_entry.weight : rd_entry.weight + 1'b1;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_tvalid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_tdata_ff <= {4'd0, rsp_weight, rsp_value, out_col, out_row};
         rsp_tuser_ff <= out_landed;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;

endmodule

// ----- rtl/fwsa_port_checker.sv -----
// Port-level checker for the splat accumulator, bound to the top level.
// Depends on fwsa_pkg and forward_warp_splat_accumulate_assert.svh.
`include "forward_warp_splat_accumulate_assert.svh"

module fwsa_port_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_tvalid,
   input logic                             req_tready,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [fwsa_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   input logic                             rsp_tuser
);

   // reset starts the clearing pass with nothing on the output
   `FWSA_ASSERT_NEXT(a_reset_quiet, clock, 1'b0, reset, !req_tready && !rsp_tvalid, "busy after reset")

   // one item in flight: no request taken right after another
   `FWSA_ASSERT_NEXT(a_one_in_flight, clock, reset, req_tvalid && req_tready, !req_tready, "back-to-back request transaction")

   // nonzero sums only come from reads, which always report landed
   `FWSA_ASSERT_SAME(a_sums_landed, clock, reset, rsp_tvalid && (rsp_tdata[59:24] != 36'd0), rsp_tuser, "sums without landed")

   // a stalled result holds
   `FWSA_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser), "stalled result changed")

endmodule

bind forward_warp_splat_accumulate fwsa_port_checker u_port_checker (.*);
